// ===== src/pid_speed_regulator_macros.svh =====
// Assertion macros for the PID speed regulator.
`ifndef PID_SPEED_REGULATOR_MACROS_SVH
`define PID_SPEED_REGULATOR_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled in reset.
`define PSR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("psr assertion failed");

// Next-cycle implication, disabled in reset.
`define PSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("psr assertion failed");

`else

`define PSR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define PSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/psr_pkg.sv =====
// Types and constants shared by the PID speed regulator modules.
`timescale 1ns / 1ps

package psr_pkg;

    localparam int SPEED_W    = 10;
    localparam int ERR_W      = 11;
    localparam int DIFF_W     = 12;
    localparam int GAIN_W     = 16;
    localparam int INTEG_W    = 19;
    localparam int ACC_W      = 36;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_W      = 27;
    localparam int PROD_W     = 2 * MUL_W;

    // floor(m / 30) == (m * RCP_30) >> RCP_SHIFT for every m below 2**26
    localparam int RCP_SHIFT  = 31;
    localparam logic [MUL_W-1:0] RCP_30   = 27'd71582789;
    localparam logic [MUL_W-1:0] TICKS_PER_SECOND = 27'd30;

    localparam logic signed [23:0] INTEG_LIMIT  = 24'sd256000;
    localparam logic [12:0]        OPEN_LOOP_LIMIT = 13'd1000;
    localparam logic [DRIVE_W-1:0] DRIVE_MAX    = 16'hFFFF;

    localparam logic [GAIN_W-1:0]  GAIN_P_RESET = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLOSED_LOOP    = 2'd0,
        REG_GAIN_P         = 2'd1,
        REG_GAIN_I         = 2'd2,
        REG_GAIN_D         = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_KI,
        ST_MUL_RCP,
        ST_INTEG,
        ST_MUL_30,
        ST_MUL_KP,
        ST_ACCUM,
        ST_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        MS_ERR_KI,
        MS_RCP,
        MS_DIFF_KD,
        MS_TIMES_30,
        MS_KP_ERR
    } mul_sel_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     mul_en;
        logic     integ_en;
        logic     acc_init;
        logic     acc_add;
        logic     prev_en;
        logic     out_load;
        logic     in_ready;
    } ctrl_t;

endpackage

// ===== src/psr_mul.sv =====
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps

module psr_mul (
    input  logic                          clk,
    input  logic                          en,
    input  logic [psr_pkg::MUL_W-1:0]     op_a,
    input  logic [psr_pkg::MUL_W-1:0]     op_b,
    output logic [psr_pkg::PROD_W-1:0]    product
);
    import psr_pkg::*;

    logic [PROD_W-1:0] product_reg;
    logic [PROD_W-1:0] product_next;

    always_comb
    begin
        product_next = PROD_W'(op_a) * PROD_W'(op_b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

// ===== src/psr_ctrl.sv =====
// Sequencer that steps one item through the shared multiplier.
`timescale 1ns / 1ps

module psr_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           closed_loop,
    input  logic           out_free,
    output psr_pkg::ctrl_t ctrl
);
    import psr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = closed_loop ? ST_MUL_KI : ST_OUTPUT;
                end
            end
            ST_MUL_KI:  state_next = ST_MUL_RCP;
            ST_MUL_RCP: state_next = ST_INTEG;
            ST_INTEG:   state_next = ST_MUL_30;
            ST_MUL_30:  state_next = ST_MUL_KP;
            ST_MUL_KP:  state_next = ST_ACCUM;
            ST_ACCUM:   state_next = ST_OUTPUT;
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.mul_sel = MS_ERR_KI;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            ST_MUL_KI:
            begin
                ctrl.mul_sel = MS_ERR_KI;
                ctrl.mul_en  = 1'b1;
            end
            ST_MUL_RCP:
            begin
                ctrl.mul_sel = MS_RCP;
                ctrl.mul_en  = 1'b1;
            end
            ST_INTEG:
            begin
                ctrl.integ_en = 1'b1;
                ctrl.mul_sel  = MS_DIFF_KD;
                ctrl.mul_en   = 1'b1;
            end
            ST_MUL_30:
            begin
                ctrl.mul_sel = MS_TIMES_30;
                ctrl.mul_en  = 1'b1;
            end
            ST_MUL_KP:
            begin
                ctrl.acc_init = 1'b1;
                ctrl.mul_sel  = MS_KP_ERR;
                ctrl.mul_en   = 1'b1;
            end
            ST_ACCUM:
            begin
                ctrl.acc_add = 1'b1;
                ctrl.prev_en = 1'b1;
            end
            ST_OUTPUT:
            begin
                ctrl.out_load = out_free;
            end
            default:
            begin
                ctrl.in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/pid_speed_regulator.sv =====
// Top level of the PID speed regulator: registers, datapath and handshakes.
// In regulation mode an item goes through the accept cycle, five passes through the
// single shared 27x27 multiplier (the integrator step and clamp share the cycle of the
// third pass), one accumulate step and the output load. Open-loop mode goes from the
// accept cycle straight to the output load. The output load waits while the previous
// result has not been taken; the next item is taken once the sequencer is back in idle,
// even while a result still waits in the output register.
`timescale 1ns / 1ps

module pid_speed_regulator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [psr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [psr_pkg::SPEED_W-1:0]       speed_setpoint,
    input  logic [psr_pkg::SPEED_W-1:0]       measured_speed,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [psr_pkg::DRIVE_W-1:0]       drive_pwm
);
    import psr_pkg::*;

    `include "pid_speed_regulator_macros.svh"

    ctrl_t ctrl;

    logic              closed_loop_reg;
    logic [GAIN_W-1:0] gain_p_reg;
    logic [GAIN_W-1:0] gain_i_reg;
    logic [GAIN_W-1:0] gain_d_reg;

    logic [ERR_W-1:0]   err_reg;
    logic [ERR_W-1:0]   prev_err_reg;
    logic [INTEG_W-1:0] integ_reg;
    logic [INTEG_W-1:0] integ_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic               out_valid_reg;
    logic [DRIVE_W-1:0] drive_reg;
    logic [DRIVE_W-1:0] drive_next;

    logic               in_accept;
    logic               out_free;

    logic [MUL_W-1:0]   op_a;
    logic [MUL_W-1:0]   op_b;
    logic [PROD_W-1:0]  product;

    logic [ERR_W-1:0]   err_abs;
    logic [9:0]         err_mag;
    logic [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]  diff_abs;
    logic [10:0]        diff_mag;

    logic [21:0]        quot;
    logic [22:0]        inc;
    logic [23:0]        integ_sum;
    logic [32:0]        deriv;
    logic [ACC_W-1:0]   kp_term;
    logic [12:0]        open_x5;
    logic [9:0]         open_val;

    logic               integ_ok;
    logic               open_take;

    assign in_accept = in_valid && ctrl.in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = ctrl.in_ready;
    assign out_valid = out_valid_reg;
    assign drive_pwm = drive_reg;

    psr_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .closed_loop    (closed_loop_reg),
        .out_free       (out_free),
        .ctrl           (ctrl)
    );

    psr_mul u_mul (
        .clk     (clk),
        .en      (ctrl.mul_en),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            closed_loop_reg <= 1'b1;
            gain_p_reg      <= GAIN_P_RESET;
            gain_i_reg      <= '0;
            gain_d_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CLOSED_LOOP: closed_loop_reg <= cfg_wdata[0];
                REG_GAIN_P:      gain_p_reg      <= cfg_wdata;
                REG_GAIN_I:      gain_i_reg      <= cfg_wdata;
                REG_GAIN_D:      gain_d_reg      <= cfg_wdata;
                default:         closed_loop_reg <= closed_loop_reg;
            endcase
        end
    end

    // Sign/magnitude of the error and of its change since the last tick
    always_comb
    begin
        err_abs  = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
        err_mag  = err_abs[9:0];
        diff     = {err_reg[ERR_W-1], err_reg} - {prev_err_reg[ERR_W-1], prev_err_reg};
        diff_abs = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
        diff_mag = diff_abs[10:0];
    end

    // Operand select for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (ctrl.mul_sel)
            MS_ERR_KI:
            begin
                op_a = MUL_W'(err_mag);
                op_b = MUL_W'(gain_i_reg);
            end
            MS_RCP:
            begin
                op_a = MUL_W'(product[25:0]);
                op_b = RCP_30;
            end
            MS_DIFF_KD:
            begin
                op_a = MUL_W'(diff_mag);
                op_b = MUL_W'(gain_d_reg);
            end
            MS_TIMES_30:
            begin
                op_a = product[MUL_W-1:0];
                op_b = TICKS_PER_SECOND;
            end
            MS_KP_ERR:
            begin
                op_a = MUL_W'(err_mag);
                op_b = MUL_W'(gain_p_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Integrator step, derivative term and accumulation
    always_comb
    begin
        quot      = product[RCP_SHIFT+21:RCP_SHIFT];
        inc       = err_reg[ERR_W-1] ? (~{1'b0, quot} + 1'b1) : {1'b0, quot};
        integ_sum = {{5{integ_reg[INTEG_W-1]}}, integ_reg} + {inc[22], inc};
        if ($signed(integ_sum) > INTEG_LIMIT)
        begin
            integ_next = INTEG_W'(INTEG_LIMIT);
        end
        else if ($signed(integ_sum) < -INTEG_LIMIT)
        begin
            integ_next = INTEG_W'(-INTEG_LIMIT);
        end
        else
        begin
            integ_next = integ_sum[INTEG_W-1:0];
        end

        // Drop the derivative when the last error was zero
        if (prev_err_reg == '0)
        begin
            deriv = '0;
        end
        else if (diff[DIFF_W-1])
        begin
            deriv = ~{1'b0, product[31:0]} + 1'b1;
        end
        else
        begin
            deriv = {1'b0, product[31:0]};
        end

        kp_term = ACC_W'(product[25:0]);

        open_x5  = {1'b0, speed_setpoint, 2'b00} + {3'b000, speed_setpoint};
        open_val = (open_x5 > OPEN_LOOP_LIMIT) ? OPEN_LOOP_LIMIT[9:0] : open_x5[9:0];

        acc_next = acc_reg;
        if (in_accept && !closed_loop_reg)
        begin
            acc_next = {18'b0, open_val, 8'b0};
        end
        else if (ctrl.acc_init)
        begin
            acc_next = {{17{integ_reg[INTEG_W-1]}}, integ_reg}
                     + {{3{deriv[32]}}, deriv};
        end
        else if (ctrl.acc_add)
        begin
            acc_next = err_reg[ERR_W-1] ? (acc_reg - kp_term) : (acc_reg + kp_term);
        end
    end

    // Clamp at zero, truncate the fraction, saturate at the top
    always_comb
    begin
        if (acc_reg[ACC_W-1])
        begin
            drive_next = '0;
        end
        else if (|acc_reg[ACC_W-2:24])
        begin
            drive_next = DRIVE_MAX;
        end
        else
        begin
            drive_next = acc_reg[23:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            if (ctrl.integ_en)
            begin
                integ_reg <= integ_next;
            end
            if (ctrl.prev_en)
            begin
                prev_err_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            err_reg <= {1'b0, speed_setpoint} - {1'b0, measured_speed};
        end
        acc_reg <= acc_next;
        if (ctrl.out_load)
        begin
            drive_reg <= drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign integ_ok  = ($signed(integ_reg) <= $signed(INTEG_W'(INTEG_LIMIT)))
                    && ($signed(integ_reg) >= $signed(INTEG_W'(-INTEG_LIMIT)));
    assign open_take = in_accept && !closed_loop_reg;

    `PSR_ASSERT_IMPL(a_integ_range, clk, rst_n, 1'b1, integ_ok)
    `PSR_ASSERT_IMPL(a_open_loop_limit, clk, rst_n, out_valid_reg && !closed_loop_reg, drive_reg <= 16'd1000)
    `PSR_ASSERT_NEXT(a_open_loop_state, clk, rst_n, open_take, $stable(prev_err_reg) && $stable(integ_reg))
    `PSR_ASSERT_IMPL(a_no_take_while_busy, clk, rst_n, ctrl.mul_en || ctrl.acc_add, !in_ready)

endmodule

// ===== test/tb_pid_speed_regulator.sv =====
// Self-checking testbench for the PID speed regulator with a built-in predictor.
`timescale 1ns / 1ps

module tb_pid_speed_regulator;

    import psr_pkg::*;

    localparam int  OPEN_LOOP_GAIN = 5;
    localparam int  OPEN_LOOP_CAP  = 1000;
    localparam int  TICK_RATE      = 30;
    localparam int  INTEG_CAP      = 256000;
    localparam int  PWM_TOP        = 65535;
    localparam int  SPEED_TOP      = 1023;
    localparam int  RANDOM_PHASES  = 10;
    localparam int  PHASE_ITEMS    = 65;
    localparam int  CYCLE_LIMIT    = 200000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;
    logic                    in_valid;
    logic                    in_ready;
    logic [SPEED_W-1:0]      speed_setpoint;
    logic [SPEED_W-1:0]      measured_speed;
    logic                    out_valid;
    logic                    out_ready;
    logic [DRIVE_W-1:0]      drive_pwm;

    // Predictor copy of the registers and the loop state
    logic                    regulate    = 1'b1;
    logic [GAIN_W-1:0]       gain_p      = 16'd256;
    logic [GAIN_W-1:0]       gain_i      = 16'd0;
    logic [GAIN_W-1:0]       gain_d      = 16'd0;
    logic signed [INTEG_W-1:0] integ_q8  = '0;
    logic signed [ERR_W-1:0] last_error  = '0;

    logic [DRIVE_W-1:0]      expected_drive[$];
    logic [DRIVE_W-1:0]      drive_want;
    int                      mismatch_count = 0;
    int                      cycle_count    = 0;
    int                      in_gap_max     = 8;
    int                      out_stall_max  = 8;

    pid_speed_regulator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .speed_setpoint (speed_setpoint),
        .measured_speed (measured_speed),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_pwm      (drive_pwm)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [DRIVE_W-1:0] predict_drive(input logic [SPEED_W-1:0] tgt,
                                                        input logic [SPEED_W-1:0] meas);
        longint t;
        longint m;
        longint kp;
        longint ki;
        longint kd;
        longint err;
        longint incr;
        longint deriv;
        longint acc;
        t     = tgt;
        m     = meas;
        kp    = gain_p;
        ki    = gain_i;
        kd    = gain_d;
        deriv = 0;
        if (!regulate)
        begin
            acc = t * OPEN_LOOP_GAIN;
            if (acc > OPEN_LOOP_CAP)
                acc = OPEN_LOOP_CAP;
            return acc[DRIVE_W-1:0];
        end
        err  = t - m;
        // division truncates toward zero, also for a negative error
        incr = (err * ki) / TICK_RATE;
        acc  = longint'(integ_q8) + incr;
        if (acc > INTEG_CAP)
            acc = INTEG_CAP;
        if (acc < -INTEG_CAP)
            acc = -INTEG_CAP;
        integ_q8 = acc[INTEG_W-1:0];
        if (last_error != 0)
            deriv = (err - longint'(last_error)) * kd * TICK_RATE;
        last_error = err[ERR_W-1:0];
        acc = kp * err + longint'(integ_q8) + deriv;
        if (acc < 0)
            return '0;
        acc = acc >>> 8;
        if (acc > PWM_TOP)
            acc = PWM_TOP;
        return acc[DRIVE_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 1023));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_speeds(input logic [SPEED_W-1:0] tgt, input logic [SPEED_W-1:0] meas);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        speed_setpoint <= tgt;
        measured_speed <= meas;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_drive = {expected_drive, predict_drive(tgt, meas)};
    endtask

    // Drop valid and wait until every result is out, so the block sits idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_CLOSED_LOOP:    regulate = value[0];
            REG_GAIN_P:         gain_p   = value;
            REG_GAIN_I:         gain_i   = value;
            REG_GAIN_D:         gain_d   = value;
            default:            ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_speeds(10'd1023, 10'd0);
        send_speeds(10'd0, 10'd1023);
        send_speeds(10'd0, 10'd0);
        send_speeds(10'd1023, 10'd1023);
        settle();
    endtask

    task automatic test_gain_extremes();
        write_reg(REG_GAIN_P, 16'hFFFF);
        write_reg(REG_GAIN_I, 16'hFFFF);
        write_reg(REG_GAIN_D, 16'hFFFF);
        send_speeds(10'd1023, 10'd0);   // no derivative yet, saturates
        send_speeds(10'd0, 10'd1023);   // large negative step, clamps to zero
        send_speeds(10'd1023, 10'd0);
        send_speeds(10'd5, 10'd5);      // zero error, derivative still active
        send_speeds(10'd6, 10'd5);      // previous error zero, derivative skipped
        settle();
        // integrator alone, pinned at its upper bound
        write_reg(REG_GAIN_P, 16'd0);
        write_reg(REG_GAIN_D, 16'd0);
        send_speeds(10'd1023, 10'd0);
        settle();
        write_reg(REG_GAIN_I, 16'd0);
        send_speeds(10'd512, 10'd512);
        settle();
    endtask

    task automatic test_open_loop();
        write_reg(REG_GAIN_P, 16'd256);
        write_reg(REG_GAIN_I, 16'd300);
        write_reg(REG_GAIN_D, 16'd40);
        send_speeds(10'd400, 10'd350);
        settle();
        // upper bits of the write are dropped
        write_reg(REG_CLOSED_LOOP, 16'hFFFE);
        send_speeds(10'd0, 10'd1023);
        send_speeds(10'd1, 10'd0);
        send_speeds(10'd199, 10'd500);
        send_speeds(10'd200, 10'd200);
        send_speeds(10'd201, 10'd1023);
        send_speeds(10'd1023, 10'd0);
        settle();
        // loop state must carry over from before the open-loop stretch
        write_reg(REG_CLOSED_LOOP, 16'hFFFF);
        send_speeds(10'd300, 10'd300);
        send_speeds(10'd300, 10'd200);
        settle();
    endtask

    task automatic test_random();
        int phase;
        int n;
        int t;
        int m;
        logic mode;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            in_gap_max    = (phase & 1) ? 8 : 0;
            out_stall_max = (phase & 2) ? 8 : 0;
            mode = ((phase % 4) != 3);
            write_reg(REG_CLOSED_LOOP, {15'($urandom), mode});
            write_reg(REG_GAIN_P, pick_gain());
            write_reg(REG_GAIN_I, pick_gain());
            write_reg(REG_GAIN_D, pick_gain());
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        t = $urandom_range(0, SPEED_TOP);
                        m = $urandom_range(0, SPEED_TOP);
                    end
                    1:
                    begin
                        // measured tracks target closely, as in a settled loop
                        t = $urandom_range(0, SPEED_TOP);
                        m = t + $urandom_range(0, 32) - 16;
                        if (m < 0)
                            m = 0;
                        if (m > SPEED_TOP)
                            m = SPEED_TOP;
                    end
                    2:
                    begin
                        t = $urandom_range(0, 1) ? SPEED_TOP : 0;
                        m = $urandom_range(0, 1) ? SPEED_TOP : 0;
                    end
                    default:
                    begin
                        t = $urandom_range(0, 63);
                        m = $urandom_range(0, 63);
                    end
                endcase
                send_speeds(10'(t), 10'(m));
            end
        end
        settle();
    endtask

    // Result side: stall a random number of cycles, then take one item
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, out_stall_max);
            @(negedge clk);
            out_ready <= (stall == 0);
            if (stall > 0)
            begin
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_drive.size() == 0)
            begin
                $display("%0t: drive_pwm expected none, got %0d", $time, drive_pwm);
                mismatch_count++;
            end
            else
            begin
                drive_want = expected_drive.pop_front();
                if (drive_pwm !== drive_want)
                begin
                    $display("%0t: drive_pwm expected %0d, got %0d", $time, drive_want,
                             drive_pwm);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_CLOSED_LOOP;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        speed_setpoint = '0;
        measured_speed = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_gain_extremes();
        test_open_loop();
        test_random();

        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
